@@ hw/rtl/als_pkg.sv @@
// als_pkg: widths, register indexes and shared types of the antialiased line shear
// no dependencies; imported by every module of the block
package als_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int SHEAR_W    = 18;
    localparam int OFFSET_W   = 11;
    localparam int LENGTH_W   = 12;
    localparam int LINE_W     = 10;
    localparam int POSIN_W    = 10;
    localparam int POSOUT_W   = 11;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 4;
    localparam int CFG_W      = 18;
    localparam int CFG_IDX_W  = 2;

    // full product of shear and line index, its whole part and the shifted position
    localparam int PROD_W     = SHEAR_W + LINE_W + 1;
    localparam int WHOLE_W    = PROD_W - FRAC_BITS;
    localparam int POS_W      = WHOLE_W + 2;

    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = 2;
    localparam int Q_CNT_W    = 3;

    localparam logic [LENGTH_W-1:0] LENGTH_CAP   = 12'd2048;
    localparam logic [LENGTH_W-1:0] LENGTH_RESET = 12'd1024;

    localparam logic [CFG_IDX_W-1:0] CFG_SHEAR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd2;

    typedef logic [NUM_CH-1:0][CH_W-1:0] color_t;

    // classified pixel as it travels from front to back
    typedef struct packed {
        logic [LINE_W-1:0]      line;
        logic signed [POS_W-1:0] pos;
        logic [FRAC_BITS-1:0]   frac;
        color_t                 color;
        logic                   last;
    } als_item_t;

    typedef struct packed {
        logic [LINE_W-1:0]   line;
        logic [POSOUT_W-1:0] pos;
        color_t              color;
        logic                done;
    } als_result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } als_qstat_t;

endpackage

@@ hw/rtl/als_front.sv @@
// als_front: accepts input pixels, computes shift and fraction per line
// depends on als_pkg; feeds als_queue
module als_front import als_pkg::*; (
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [LINE_W-1:0]   s_line_index,
    input  logic [POSIN_W-1:0]  s_position,
    input  color_t              s_color,
    input  logic                s_line_end,
    input  logic [SHEAR_W-1:0]  shear,
    input  logic [OFFSET_W-1:0] offset,
    input  als_qstat_t          q_stat,
    output logic                push,
    output als_item_t           push_item
);

    logic [PROD_W-1:0]       shear_ext;
    logic [PROD_W-1:0]       line_ext;
    logic [PROD_W-1:0]       prod;
    logic [WHOLE_W-1:0]      whole;

    assign s_ready = !q_stat.full;
    assign push    = s_valid && s_ready;

    // low bits of the unsigned product equal the two's complement product
    assign shear_ext = {{(PROD_W-SHEAR_W){shear[SHEAR_W-1]}}, shear};
    assign line_ext  = {{(PROD_W-LINE_W){1'b0}}, s_line_index};
    assign prod      = shear_ext * line_ext;
    assign whole     = prod[PROD_W-1:FRAC_BITS];

    always_comb begin
        push_item.line  = s_line_index;
        push_item.frac  = prod[FRAC_BITS-1:0];
        push_item.pos   = $signed({{(POS_W-WHOLE_W){whole[WHOLE_W-1]}}, whole})
                        + $signed({{(POS_W-OFFSET_W){1'b0}}, offset})
                        + $signed({{(POS_W-POSIN_W){1'b0}}, s_position});
        push_item.color = s_color;
        push_item.last  = s_line_end;
    end

endmodule

@@ hw/rtl/als_queue.sv @@
// als_queue: small first-in first-out buffer between front and back
// depends on als_pkg
module als_queue import als_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  als_item_t  push_item,
    input  logic       pop,
    output als_item_t  head_item,
    output als_qstat_t q_stat
);

    als_item_t            mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;

    assign q_stat.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head_item    = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ hw/rtl/als_back.sv @@
// als_back: blends each pixel with the running carry and delivers up to two results
// depends on als_pkg; pops from als_queue
module als_back import als_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  als_item_t           head_item,
    input  als_qstat_t          q_stat,
    output logic                pop,
    input  logic [LENGTH_W-1:0] length,
    output logic                m_valid,
    input  logic                m_ready,
    output als_result_t         m_result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } state_t;

    state_t      state_reg, state_next;
    als_item_t   item_reg, item_next;
    color_t      carry_reg, carry_next;
    logic        a_valid_reg, a_valid_next;
    logic        b_valid_reg, b_valid_next;
    als_result_t a_res_reg, a_res_next;
    als_result_t b_res_reg, b_res_next;

    logic [LENGTH_W-1:0]         len_eff;
    logic signed [POS_W-1:0]     pos_end;
    logic                        pix_in;
    logic                        end_in;
    logic [CH_W+FRAC_BITS-1:0]   ch_prod [NUM_CH];
    color_t                      left;
    color_t                      pix;
    logic [CH_W:0]               ch_sum [NUM_CH];

    assign len_eff = (length > LENGTH_CAP) ? LENGTH_CAP : length;
    assign pos_end = item_reg.pos + POS_W'(1);
    assign pix_in  = !item_reg.pos[POS_W-1]
                   && (item_reg.pos < $signed({{(POS_W-LENGTH_W){1'b0}}, len_eff}));
    assign end_in  = item_reg.last && !pos_end[POS_W-1]
                   && (pos_end < $signed({{(POS_W-LENGTH_W){1'b0}}, len_eff}));

    // per channel share moved right, then blend with the carry
    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            ch_prod[k] = (CH_W+FRAC_BITS)'(item_reg.color[k])
                       * (CH_W+FRAC_BITS)'(item_reg.frac);
            left[k]    = ch_prod[k][CH_W+FRAC_BITS-1:FRAC_BITS];
            ch_sum[k]  = {1'b0, item_reg.color[k]} - {1'b0, left[k]}
                       + {1'b0, carry_reg[k]};
            pix[k]     = ch_sum[k][CH_W] ? {CH_W{1'b1}} : ch_sum[k][CH_W-1:0];
        end
    end

    assign m_valid  = a_valid_reg || b_valid_reg;
    assign m_result = a_valid_reg ? a_res_reg : b_res_reg;

    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        carry_next   = carry_reg;
        a_valid_next = a_valid_reg;
        b_valid_next = b_valid_reg;
        a_res_next   = a_res_reg;
        b_res_next   = b_res_reg;
        pop          = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (!q_stat.empty) begin
                    pop        = 1'b1;
                    item_next  = head_item;
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                carry_next       = item_reg.last ? '0 : left;
                a_valid_next     = pix_in;
                a_res_next.line  = item_reg.line;
                a_res_next.pos   = item_reg.pos[POSOUT_W-1:0];
                a_res_next.color = pix;
                a_res_next.done  = item_reg.last && !end_in;
                b_valid_next     = end_in;
                b_res_next.line  = item_reg.line;
                b_res_next.pos   = pos_end[POSOUT_W-1:0];
                b_res_next.color = left;
                b_res_next.done  = 1'b1;
                state_next       = (pix_in || end_in) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (m_ready) begin
                    if (a_valid_reg) begin
                        a_valid_next = 1'b0;
                    end else begin
                        b_valid_next = 1'b0;
                    end
                    if (a_valid_reg != b_valid_reg) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            carry_reg   <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            carry_reg   <= carry_next;
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
        item_reg  <= item_next;
        a_res_reg <= a_res_next;
        b_res_reg <= b_res_next;
    end

endmodule

@@ hw/rtl/antialiased_line_shear.sv @@
// antialiased_line_shear: top level of one blended shear pass
// depends on als_pkg, als_front, als_queue, als_back
//
// One pass of a three-shear rotation with blending. Pixels of a line arrive in
// order; each is moved by floor(shear_factor * line_index) + shift_offset and
// gives up the fraction of each channel to the next output pixel, the leftover
// carry landing one column past the last pixel when line_end is set. Results
// whose position is negative or at or beyond output_length (capped at 2048) are
// dropped, but the carry still advances. The front takes one request per clock
// while the four-entry queue has room and computes the shift with one multiply.
// The back works on one pixel at a time: it pops in ST_IDLE, does the channel
// multiplies and carry blend in ST_CALC, and delivers each result in ST_EMIT
// as m_ready takes it; the carry is serial state in the back. The user must
// write configuration through cfg_we/cfg_index/cfg_wdata only while the block
// is idle; the block itself does not enforce this.
module antialiased_line_shear import als_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration writes
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // input pixel requests
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [LINE_W-1:0]    s_line_index,
    input  logic [POSIN_W-1:0]   s_position,
    input  logic [CH_W-1:0]      s_red_in,
    input  logic [CH_W-1:0]      s_green_in,
    input  logic [CH_W-1:0]      s_blue_in,
    input  logic [CH_W-1:0]      s_opacity_in,
    input  logic                 s_line_end,
    // result requests
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [LINE_W-1:0]    m_line_out,
    output logic [POSOUT_W-1:0]  m_out_position,
    output logic [CH_W-1:0]      m_red_out,
    output logic [CH_W-1:0]      m_green_out,
    output logic [CH_W-1:0]      m_blue_out,
    output logic [CH_W-1:0]      m_opacity_out,
    output logic                 m_line_done
);

    // configuration registers
    logic [SHEAR_W-1:0]  shear_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [LENGTH_W-1:0] length_reg;

    // front to queue to back
    logic        push;
    als_item_t   push_item;
    logic        pop;
    als_item_t   head_item;
    als_qstat_t  q_stat;
    als_result_t m_result;
    color_t      s_color;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shear_reg  <= '0;
            offset_reg <= '0;
            length_reg <= LENGTH_RESET;
        end else if (cfg_we) begin
            // writes to an index past the list are ignored
            case (cfg_index)
                CFG_SHEAR:  shear_reg  <= cfg_wdata[SHEAR_W-1:0];
                CFG_OFFSET: offset_reg <= cfg_wdata[OFFSET_W-1:0];
                CFG_LENGTH: length_reg <= cfg_wdata[LENGTH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // channel order red, green, blue, opacity from low to high
    assign s_color = {s_opacity_in, s_blue_in, s_green_in, s_red_in};

    als_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_line_index (s_line_index),
        .s_position   (s_position),
        .s_color      (s_color),
        .s_line_end   (s_line_end),
        .shear        (shear_reg),
        .offset       (offset_reg),
        .q_stat       (q_stat),
        .push         (push),
        .push_item    (push_item)
    );

    als_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_stat    (q_stat)
    );

    als_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_item (head_item),
        .q_stat    (q_stat),
        .pop       (pop),
        .length    (length_reg),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result)
    );

    // result fields
    assign m_line_out     = m_result.line;
    assign m_out_position = m_result.pos;
    assign m_red_out      = m_result.color[0];
    assign m_green_out    = m_result.color[1];
    assign m_blue_out     = m_result.color[2];
    assign m_opacity_out  = m_result.color[3];
    assign m_line_done    = m_result.done;

endmodule

@@ hw/rtl/als_checker.sv @@
// als_checker: port-level assertions for antialiased_line_shear, with its bind
// depends on als_pkg; bound to the top level
module als_checker import als_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [LINE_W-1:0]    m_line_out,
    input  logic [POSOUT_W-1:0]  m_out_position,
    input  logic [CH_W-1:0]      m_red_out,
    input  logic [CH_W-1:0]      m_green_out,
    input  logic [CH_W-1:0]      m_blue_out,
    input  logic [CH_W-1:0]      m_opacity_out,
    input  logic                 m_line_done
);

    // shadow of the output length register
    logic [LENGTH_W-1:0] len_reg, len_next;
    logic [LENGTH_W-1:0] len_eff;

    assign len_next = (cfg_we && (cfg_index == CFG_LENGTH)) ? cfg_wdata[LENGTH_W-1:0]
                                                            : len_reg;
    assign len_eff  = (len_reg > LENGTH_CAP) ? LENGTH_CAP : len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= LENGTH_RESET;
        end else begin
            len_reg <= len_next;
        end
    end

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result valid dropped before accept");

    a_payload_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_line_out) && $stable(m_out_position)
            && $stable(m_red_out) && $stable(m_green_out) && $stable(m_blue_out)
            && $stable(m_opacity_out) && $stable(m_line_done))
        else $error("stalled result changed");

    a_pos_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_out_position} < len_eff))
        else $error("result position beyond output length");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind antialiased_line_shear als_checker u_als_checker (.*);
